>>> src/bpn_pkg.sv
// ----------------------------------------------------------------------------
// bpn_pkg
// Shared constants, types and helpers of the block peak normalizer.
// ----------------------------------------------------------------------------
package bpn_pkg;

   localparam int BLOCK_SIZE     = 1024;
   localparam int POS_WIDTH      = $clog2(BLOCK_SIZE);
   localparam int ADDR_WIDTH     = POS_WIDTH + 1;
   localparam int STORE_DEPTH    = 2 ** ADDR_WIDTH;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int PEAK_WIDTH     = 16;
   localparam int QUOT_WIDTH     = 16;
   localparam int SCALED_WIDTH   = 17;
   localparam int REM_WIDTH      = 17;
   localparam int DIV_STEPS      = QUOT_WIDTH;
   localparam int STEP_CNT_WIDTH = $clog2(DIV_STEPS + 1);
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 40;

   localparam logic [POS_WIDTH-1:0]    LAST_POS   = POS_WIDTH'(BLOCK_SIZE - 1);
   localparam logic [SCALED_WIDTH-1:0] FULL_SCALE = SCALED_WIDTH'(32768);

   typedef struct packed {
      logic                    start;
      logic [PEAK_WIDTH-1:0]   magnitude;
      logic [PEAK_WIDTH-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [QUOT_WIDTH-1:0]   quotient;
   } div_rsp_type;

   // |x| of a signed sample, the most negative value gives 32768
   function automatic logic [PEAK_WIDTH-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] raw);
      logic [PEAK_WIDTH-1:0] mag;
      if (raw[SAMPLE_WIDTH-1]) begin
         mag = PEAK_WIDTH'(-raw);
      end else begin
         mag = PEAK_WIDTH'(raw);
      end
      return mag;
   endfunction

endpackage

>>> src/block_peak_normalizer_unit.sv
// After the first block, each accepted sample passes the store read, the 16
// steps of the shared divider and the output load; no new sample is taken until
// its result is loaded, which waits on rsp_tready. The first block gives no results.
// Reset clears the block position, bank, peaks and handshake state; the sample
// store is not cleared, as no value read from it is used before it is written.
// ----------------------------------------------------------------------------
// block_peak_normalizer_unit
// Stores each block of samples in one bank of a two-bank RAM, tracks its peak
// and emits the previous block scaled by 32768 / peak, one block behind.
// ----------------------------------------------------------------------------
module block_peak_normalizer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bpn_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,  // sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [bpn_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,  // scaled_sample, block_peak
   output logic                                   rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic [bpn_pkg::POS_WIDTH-1:0]        pos_ff, pos_in;
   logic                                 bank_ff, bank_in;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       run_peak_ff, run_peak_in;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       prev_peak_ff, prev_peak_in;
   logic                                 prev_valid_ff, prev_valid_in;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       item_peak_ff, item_peak_in;
   logic                                 item_last_ff, item_last_in;
   logic                                 item_neg_ff, item_neg_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [bpn_pkg::SCALED_WIDTH-1:0]     rsp_scaled_ff, rsp_scaled_in;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       rsp_peak_ff, rsp_peak_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 req_accept;
   logic                                 at_last;
   logic                                 rsp_load;
   logic [bpn_pkg::SAMPLE_WIDTH-1:0]     sample;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       sample_mag;
   logic [bpn_pkg::PEAK_WIDTH-1:0]       new_peak;
   logic [bpn_pkg::SAMPLE_WIDTH-1:0]     old_sample;
   logic [bpn_pkg::SCALED_WIDTH-1:0]     quot_ext;
   logic [bpn_pkg::SCALED_WIDTH-1:0]     quot_sat;
   bpn_pkg::div_req_type                 div_req;
   bpn_pkg::div_rsp_type                 div_rsp;

   assign sample     = req_tdata[bpn_pkg::SAMPLE_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign at_last    = (pos_ff == bpn_pkg::LAST_POS);
   assign sample_mag = bpn_pkg::magnitude(sample);
   assign new_peak   = (sample_mag > run_peak_ff) ? sample_mag : run_peak_ff;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   bpn_ram #(
      .WIDTH (bpn_pkg::SAMPLE_WIDTH),
      .DEPTH (bpn_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr ({bank_ff, pos_ff}),
      .wr_data (sample),
      .rd_en   (req_accept),
      .rd_addr ({~bank_ff, pos_ff}),
      .rd_data (old_sample)
   );

   assign div_req.start     = (state_ff == ST_READ);
   assign div_req.magnitude = bpn_pkg::magnitude(old_sample);
   assign div_req.divisor   = item_peak_ff;

   bpn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign quot_ext = bpn_pkg::SCALED_WIDTH'(div_rsp.quotient);
   assign quot_sat = (quot_ext > bpn_pkg::FULL_SCALE) ? bpn_pkg::FULL_SCALE : quot_ext;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      bank_in       = bank_ff;
      run_peak_in   = run_peak_ff;
      prev_peak_in  = prev_peak_ff;
      prev_valid_in = prev_valid_ff;
      item_peak_in  = item_peak_ff;
      item_last_in  = item_last_ff;
      item_neg_in   = item_neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_peak_in = prev_peak_ff;
               item_last_in = at_last;
               if (at_last) begin
                  prev_peak_in  = new_peak;
                  run_peak_in   = '0;
                  bank_in       = ~bank_ff;
                  prev_valid_in = 1'b1;
                  pos_in        = '0;
               end else begin
                  run_peak_in = new_peak;
                  pos_in      = pos_ff + 1'b1;
               end
               if (prev_valid_ff) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            item_neg_in = old_sample[bpn_pkg::SAMPLE_WIDTH-1];
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_peak_in  = item_peak_ff;
               rsp_last_in  = item_last_ff;
               if (item_peak_ff == '0) begin
                  rsp_scaled_in = '0;
               end else if (item_neg_ff) begin
                  rsp_scaled_in = -quot_sat;
               end else begin
                  rsp_scaled_in = quot_sat;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         bank_ff       <= 1'b0;
         run_peak_ff   <= '0;
         prev_peak_ff  <= '0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         bank_ff       <= bank_in;
         run_peak_ff   <= run_peak_in;
         prev_peak_ff  <= prev_peak_in;
         prev_valid_ff <= prev_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_peak_ff  <= item_peak_in;
      item_last_ff  <= item_last_in;
      item_neg_ff   <= item_neg_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {
      (bpn_pkg::RSP_DATA_WIDTH - bpn_pkg::SCALED_WIDTH - bpn_pkg::PEAK_WIDTH)'(0),
      rsp_peak_ff,
      rsp_scaled_ff
   };

endmodule

>>> src/bpn_ram.sv
// ----------------------------------------------------------------------------
// bpn_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bpn_divider.sv
// ----------------------------------------------------------------------------
// bpn_divider
// Restoring divider, one quotient bit per cycle: floor(magnitude * 2^15 / divisor)
// for magnitude no larger than divisor.
// ----------------------------------------------------------------------------
module bpn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bpn_pkg::div_req_type div_req,
   output bpn_pkg::div_rsp_type div_rsp
);

   logic [bpn_pkg::REM_WIDTH-1:0]      rem_ff, rem_in;
   logic [bpn_pkg::QUOT_WIDTH-1:0]     quot_ff, quot_in;
   logic [bpn_pkg::STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [bpn_pkg::PEAK_WIDTH-1:0]     divisor_ff, divisor_in;
   logic                               done_ff, done_in;
   logic [bpn_pkg::REM_WIDTH-1:0]      diff;
   logic                               take;

   assign diff = rem_ff - bpn_pkg::REM_WIDTH'(divisor_ff);
   assign take = rem_ff >= bpn_pkg::REM_WIDTH'(divisor_ff);

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = bpn_pkg::REM_WIDTH'(div_req.magnitude);
         quot_in    = '0;
         cnt_in     = bpn_pkg::STEP_CNT_WIDTH'(bpn_pkg::DIV_STEPS);
         divisor_in = div_req.divisor;
      end else if (cnt_ff != '0) begin
         if (take) begin
            rem_in = {diff[bpn_pkg::REM_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = {rem_ff[bpn_pkg::REM_WIDTH-2:0], 1'b0};
         end
         quot_in = {quot_ff[bpn_pkg::QUOT_WIDTH-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == bpn_pkg::STEP_CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule
